### sv/oksrs_pkg.sv
// shared types, constants and widths for the ordered key set range sum block
package oksrs_pkg;

   localparam int CAPACITY = 1024;
   localparam int KEY_W    = 30;
   localparam int SUM_W    = 40;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int REQ_W    = 96;
   localparam int RSP_W    = 48;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DUP  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_QUERY  = 1'b1
   } kind_type;

   typedef struct packed {
      logic clear;
      logic enable;
      logic is_query;
   } alu_ctrl_type;

endpackage

### sv/ordered_key_set_range_sum.sv
// top level: sequencer that scans the key table for inserts and range sum queries
//
// Every transaction walks the stored keys one per cycle through a single shared
// compare and accumulate unit fed by the key table's one read port. The response
// is registered after the last stored key has been compared and accumulated.
// req_tready is low from acceptance until the response is registered, and the
// next request can be accepted in the cycle after that. Inserts check for a
// duplicate during the scan and append the key at the end. A finished response
// sits in the output register while the next request is accepted and scanned;
// if it has still not been taken when that scan ends, the block waits and
// req_tready stays low. No clearing pass is needed after reset.
module ordered_key_set_range_sum (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // new_key[29:0], low_bound[59:30], high_bound[89:60], zero fill
   input  logic [oksrs_pkg::REQ_W-1:0]   req_tdata,
   // kind
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // range_sum[39:0], status[41:40], zero fill
   output logic [oksrs_pkg::RSP_W-1:0]   rsp_tdata
);
   import oksrs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic             kind_ff, kind_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] low_ff, low_in;
   logic [KEY_W-1:0] high_ff, high_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   status_type       rsp_status_ff, rsp_status_in;

   alu_ctrl_type     alu_ctrl;
   logic [SUM_W-1:0] alu_sum;
   logic             alu_hit;
   logic             rd_en;
   logic             wr_en;
   logic [KEY_W-1:0] rd_data;
   logic             req_fire;
   logic             slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      kind_in       = kind_ff;
      key_in        = key_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      alu_ctrl      = '{clear: 1'b0, enable: 1'b0, is_query: kind_ff};
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in        = req_tuser;
               key_in         = req_tdata[KEY_W-1:0];
               low_in         = req_tdata[2*KEY_W-1:KEY_W];
               high_in        = req_tdata[3*KEY_W-1:2*KEY_W];
               issue_in       = '0;
               alu_ctrl.clear = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            alu_ctrl.enable = pend_ff;
            if (issue_ff != count_ff) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (kind_ff == KIND_QUERY) begin
                  rsp_sum_in    = alu_sum;
                  rsp_status_in = STATUS_OK;
               end else begin
                  rsp_sum_in = '0;
                  if (alu_hit) begin
                     rsp_status_in = STATUS_DUP;
                  end else if (count_ff == COUNT_W'(CAPACITY)) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     rsp_status_in = STATUS_OK;
                     wr_en         = 1'b1;
                     count_in      = count_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      low_ff        <= low_in;
      high_ff       <= high_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   oksrs_key_mem u_key_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   oksrs_scan_alu u_scan_alu (
      .clock     (clock),
      .ctrl      (alu_ctrl),
      .entry_key (rd_data),
      .probe_key (key_ff),
      .low_key   (low_ff),
      .high_key  (high_ff),
      .sum       (alu_sum),
      .hit       (alu_hit)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - SUM_W - 2)'(0), rsp_status_ff, rsp_sum_ff};

endmodule

### sv/oksrs_key_mem.sv
// key table memory: one write port, one registered read port
module oksrs_key_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [oksrs_pkg::ADDR_W-1:0] wr_addr,
   input  logic [oksrs_pkg::KEY_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [oksrs_pkg::ADDR_W-1:0] rd_addr,
   output logic [oksrs_pkg::KEY_W-1:0]  rd_data
);
   import oksrs_pkg::*;

   logic [KEY_W-1:0] mem_ff [CAPACITY];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/oksrs_scan_alu.sv
// shared compare and saturating accumulate unit applied to one stored key per cycle
module oksrs_scan_alu (
   input  logic                          clock,
   input  oksrs_pkg::alu_ctrl_type       ctrl,
   input  logic [oksrs_pkg::KEY_W-1:0]   entry_key,
   input  logic [oksrs_pkg::KEY_W-1:0]   probe_key,
   input  logic [oksrs_pkg::KEY_W-1:0]   low_key,
   input  logic [oksrs_pkg::KEY_W-1:0]   high_key,
   output logic [oksrs_pkg::SUM_W-1:0]   sum,
   output logic                          hit
);
   import oksrs_pkg::*;

   logic [SUM_W-1:0] acc_ff, acc_in;
   logic             hit_ff, hit_in;
   logic [SUM_W:0]   sum_ext;
   logic             in_range;

   always_comb begin
      sum_ext  = {1'b0, acc_ff} + (SUM_W + 1)'(entry_key);
      in_range = (entry_key >= low_key) && (entry_key <= high_key);
      acc_in   = acc_ff;
      hit_in   = hit_ff;
      if (ctrl.clear) begin
         acc_in = '0;
         hit_in = 1'b0;
      end else if (ctrl.enable) begin
         if (ctrl.is_query) begin
            if (in_range) begin
               acc_in = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
            end
         end else if (entry_key == probe_key) begin
            hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      hit_ff <= hit_in;
   end

   assign sum = acc_ff;
   assign hit = hit_ff;

endmodule

### verif/ordered_key_set_range_sum_tb.sv
// self-checking testbench for the ordered key set range sum block
module ordered_key_set_range_sum_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import oksrs_pkg::*;

   typedef logic [KEY_W-1:0] key_type;

   typedef struct {
      logic [SUM_W-1:0] sum;
      status_type       status;
   } key_result_type;

   localparam key_type          KEY_MAX       = '1;
   localparam logic [SUM_W-1:0] SUM_SAT       = '1;
   localparam key_type          WINDOW_BASE   = 30'h2000_0000;
   localparam int               STALL_LIMIT   = 20000;
   localparam int               DRAIN_CYCLES  = CAPACITY + 100;
   localparam int               PRESSURE_HOLD = 2500;
   localparam int               REPORT_LIMIT  = 10;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tuser = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   key_type        stored_keys[$];
   key_result_type pending_results[$];
   int             error_count = 0;
   bit             idle_enable = 1'b1;
   int             hold_request = 0;

   ordered_key_set_range_sum DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit key_stored(key_type key);
      bit found;
      found = 1'b0;
      foreach (stored_keys[i])
         if (stored_keys[i] == key)
            found = 1'b1;
      return found;
   endfunction

   // updates the shadow key table and returns the result the block owes
   function automatic key_result_type apply_key_op(kind_type kind, key_type key,
                                                   key_type lo, key_type hi);
      key_result_type res;
      logic [SUM_W:0] acc;
      res.sum    = '0;
      res.status = STATUS_OK;
      acc        = '0;
      if (kind == KIND_INSERT) begin
         if (key_stored(key))
            res.status = STATUS_DUP;
         else if (stored_keys.size() >= CAPACITY)
            res.status = STATUS_FULL;
         else
            stored_keys.push_back(key);
      end else begin
         foreach (stored_keys[i])
            if (stored_keys[i] >= lo && stored_keys[i] <= hi) begin
               acc = acc + stored_keys[i];
               if (acc > SUM_SAT)
                  acc = SUM_SAT;
            end
         res.sum = acc[SUM_W-1:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         pending_results.push_back(apply_key_op(kind_type'(req_tuser),
                                                req_tdata[KEY_W-1:0],
                                                req_tdata[2*KEY_W-1:KEY_W],
                                                req_tdata[3*KEY_W-1:2*KEY_W]));
   end

   always @(posedge clock) begin
      key_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("error: result with nothing outstanding, data %h", rsp_tdata);
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_tdata[SUM_W-1:0] !== exp_res.sum
                || rsp_tdata[SUM_W+1:SUM_W] !== exp_res.status) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("mismatch: sum %0d status %0d, got sum %0d status %0d",
                           exp_res.sum, exp_res.status,
                           rsp_tdata[SUM_W-1:0], rsp_tdata[SUM_W+1:SUM_W]);
            end
         end
      end
   end

   // response side ready, with random idling and long hold-offs on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (idle_enable && $urandom_range(99) < 38) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("ordered_key_set_range_sum verification failed");
      $finish;
   end

   // called and returns at a falling edge
   task automatic send_item(kind_type kind, key_type key, key_type lo, key_type hi);
      while (idle_enable && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_W-3*KEY_W){1'b0}}, hi, lo, key};
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
   endtask

   task automatic insert_key(key_type key);
      send_item(KIND_INSERT, key, key_type'($urandom()), key_type'($urandom()));
   endtask

   task automatic query_range(key_type lo, key_type hi);
      send_item(KIND_QUERY, key_type'($urandom()), lo, hi);
   endtask

   function automatic key_type pick_key();
      int sel;
      sel = $urandom_range(99);
      if (sel < 30 && stored_keys.size() > 0)
         return stored_keys[$urandom_range(stored_keys.size() - 1)];
      else if (sel < 65)
         return key_type'(WINDOW_BASE + $urandom_range(4095));
      else if (sel < 68)
         return KEY_MAX;
      else if (sel < 70)
         return '0;
      else
         return key_type'($urandom());
   endfunction

   task automatic random_query();
      key_type a, b;
      int      sel;
      a   = pick_key();
      b   = pick_key();
      sel = $urandom_range(99);
      if (sel < 10)
         query_range((a > b) ? a : b + 1'b1, (a > b) ? b : a);
      else if (sel < 25)
         query_range(a, a);
      else if (sel < 35)
         query_range('0, KEY_MAX);
      else
         query_range((a < b) ? a : b, (a < b) ? b : a);
   endtask

   task automatic test_directed_cases();
      query_range('0, KEY_MAX);
      insert_key('0);
      insert_key(KEY_MAX);
      insert_key(30'd1);
      insert_key('0);
      insert_key(KEY_MAX);
      insert_key(30'h1555_5555);
      insert_key(30'h2AAA_AAAA);
      query_range('0, KEY_MAX);
      query_range(30'd1, 30'd1);
      query_range(KEY_MAX, KEY_MAX);
      query_range('0, '0);
      query_range(30'd5, 30'd3);
      query_range(KEY_MAX, '0);
      query_range(30'd2, KEY_MAX - 1'b1);
      query_range(30'h1555_5556, 30'h2AAA_AAA9);
      query_range(30'h1555_5555, 30'h2AAA_AAAA);
      insert_key(30'h1555_5555);
   endtask

   // response side holds off while requests keep coming
   task automatic test_backpressure();
      hold_request = PRESSURE_HOLD;
      for (int n = 0; n < 8; n++) begin
         if (n % 2 == 0)
            insert_key(pick_key());
         else
            random_query();
      end
   endtask

   task automatic test_random_traffic(int count);
      for (int n = 0; n < count; n++) begin
         idle_enable = !(n >= count / 3 && n < count / 3 + 120);
         if ($urandom_range(99) < 40)
            insert_key(pick_key());
         else
            random_query();
      end
      idle_enable = 1'b1;
   endtask

   // fill with keys near the top so the full-table sum reaches the upper bits
   task automatic test_table_full();
      key_type k;
      int      n;
      n = 0;
      while (stored_keys.size() < CAPACITY) begin
         do
            k = KEY_MAX - key_type'($urandom_range(1 << 20));
         while (key_stored(k));
         insert_key(k);
         n++;
         if (n % 128 == 0)
            random_query();
      end
      do
         k = key_type'($urandom());
      while (key_stored(k));
      insert_key(k);
      insert_key(stored_keys[0]);
      insert_key(KEY_MAX);
      insert_key('0);
      query_range('0, KEY_MAX);
      query_range(KEY_MAX, '0);
      query_range(KEY_MAX, KEY_MAX);
      for (int i = 0; i < 5; i++)
         random_query();
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_backpressure();
      test_random_traffic(560);
      test_table_full();
      req_tvalid  <= 1'b0;
      idle_enable = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         error_count++;
      if (error_count == 0)
         $display("ordered_key_set_range_sum verification clean");
      else
         $display("ordered_key_set_range_sum verification failed");
      $finish;
   end

endmodule
